/* src/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_SCL  = 3'd4,
		KIND_CONJ = 3'd5,
		KIND_MAG  = 3'd6,
		KIND_RSVD = 3'd7
	} kind_t;

endpackage

/* src/complex_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU: add, subtract, multiply, divide, scale, conjugate
// and magnitude on signed fixed-point operands, with saturation flags.
// ----------------------------------------------------------------------------
// A beat passes stages 1 to 3, the DATA_WIDTH + 1 iteration stages and the output register.
// Throughput: one beat per cycle while the output is not stalled; the divider retires one
// quotient bit per iteration stage, the square root one root bit in all but the last.
// A stalled output freezes the whole pipeline; in_stall follows it.
// Reset clears all valid bits; payload registers are not reset.
module complex_arithmetic_unit_top import cau_pkg::*; #(
	parameter int DATA_WIDTH    = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	input  logic signed [DATA_WIDTH-1:0] scale_factor,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         overflow,
	output logic                         divide_by_zero
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int WL = W + 1;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int QB = W + 1;
	localparam int NI = QB;
	localparam int XW = SW + F + QB;
	localparam int RW = W + 3;

	localparam logic [SW-1:0] POS_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [SW-1:0] NEG_MAG = {{(SW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	function automatic logic [W:0] sat_sm(input logic neg, input logic [SW-1:0] mag);
		logic [W:0] r;
		if (!neg) begin
			if (mag > POS_MAX) r = {1'b1, 1'b0, {(W-1){1'b1}}};
			else r = {1'b0, mag[W-1:0]};
		end else begin
			if (mag > NEG_MAG) r = {1'b1, 1'b1, {(W-1){1'b0}}};
			else r = {1'b0, W'(~mag[W-1:0] + 1'b1)};
		end
		return r;
	endfunction

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: products and linear terms
	logic                 vld_s1;
	kind_t                kind_s1;
	logic signed [PW-1:0] p_arbr_s1, p_aibi_s1, p_arbi_s1, p_aibr_s1;
	logic signed [PW-1:0] p_arsf_s1, p_aisf_s1, p_arar_s1, p_aiai_s1;
	logic signed [PW-1:0] p_brbr_s1, p_bibi_s1;
	logic signed [WL-1:0] lin_re_s1, lin_im_s1;
	logic signed [WL-1:0] lin_re_c, lin_im_c;

	always_comb begin
		case (kind_t'(kind))
			KIND_SUB: begin
				lin_re_c = WL'(a_re) - WL'(b_re);
				lin_im_c = WL'(a_im) - WL'(b_im);
			end
			KIND_CONJ: begin
				lin_re_c = WL'(a_re);
				lin_im_c = -WL'(a_im);
			end
			default: begin
				lin_re_c = WL'(a_re) + WL'(b_re);
				lin_im_c = WL'(a_im) + WL'(b_im);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= kind_t'(kind);
			p_arbr_s1 <= a_re * b_re;
			p_aibi_s1 <= a_im * b_im;
			p_arbi_s1 <= a_re * b_im;
			p_aibr_s1 <= a_im * b_re;
			p_arsf_s1 <= a_re * scale_factor;
			p_aisf_s1 <= a_im * scale_factor;
			p_arar_s1 <= a_re * a_re;
			p_aiai_s1 <= a_im * a_im;
			p_brbr_s1 <= b_re * b_re;
			p_bibi_s1 <= b_im * b_im;
			lin_re_s1 <= lin_re_c;
			lin_im_s1 <= lin_im_c;
		end
	end

	// stage 2: sums of products
	logic                 vld_s2;
	kind_t                kind_s2;
	logic signed [SW-1:0] pre_s2, pim_s2, nre_s2, nim_s2;
	logic [PW-1:0]        den_s2, nrm_s2;
	logic signed [WL-1:0] lin_re_s2, lin_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			if (kind_s1 == KIND_SCL) begin
				pre_s2 <= SW'(p_arsf_s1);
				pim_s2 <= SW'(p_aisf_s1);
			end else begin
				pre_s2 <= SW'(p_arbr_s1) - SW'(p_aibi_s1);
				pim_s2 <= SW'(p_arbi_s1) + SW'(p_aibr_s1);
			end
			nre_s2    <= SW'(p_arbr_s1) + SW'(p_aibi_s1);
			nim_s2    <= SW'(p_aibr_s1) - SW'(p_arbi_s1);
			den_s2    <= $unsigned(p_brbr_s1) + $unsigned(p_bibi_s1);
			nrm_s2    <= $unsigned(p_arar_s1) + $unsigned(p_aiai_s1);
			lin_re_s2 <= lin_re_s1;
			lin_im_s2 <= lin_im_s1;
		end
	end

	// stage 3 (index 0) and iteration stages
	logic          vld_sd    [NI+1];
	kind_t         kind_sd   [NI+1];
	logic [W-1:0]  dre_sd    [NI+1];
	logic [W-1:0]  dim_sd    [NI+1];
	logic          dov_sd    [NI+1];
	logic          dz_sd     [NI+1];
	logic [PW-1:0] den_sd    [NI+1];
	logic          neg_re_sd [NI+1];
	logic          neg_im_sd [NI+1];
	logic          big_re_sd [NI+1];
	logic          big_im_sd [NI+1];
	logic [XW-1:0] rem_re_sd [NI+1];
	logic [XW-1:0] rem_im_sd [NI+1];
	logic [QB-1:0] q_re_sd   [NI+1];
	logic [QB-1:0] q_im_sd   [NI+1];
	logic [PW-1:0] x_sd      [NI+1];
	logic [RW-1:0] srem_sd   [NI+1];
	logic [W-1:0]  root_sd   [NI+1];

	logic [W-1:0]  dre_c, dim_c;
	logic          dov_c;
	logic          nre_neg_c, nim_neg_c;
	logic [SW-1:0] nre_mag_c, nim_mag_c, pre_mag_c, pim_mag_c, lre_mag_c, lim_mag_c;
	logic [XW-1:0] rre0_c, rim0_c, dtop_c;
	logic [W:0]    sa_c, sb_c;

	always_comb begin
		nre_neg_c = nre_s2[SW-1];
		nim_neg_c = nim_s2[SW-1];
		nre_mag_c = nre_neg_c ? SW'(-nre_s2) : SW'(nre_s2);
		nim_mag_c = nim_neg_c ? SW'(-nim_s2) : SW'(nim_s2);
		pre_mag_c = (pre_s2[SW-1] ? SW'(-pre_s2) : SW'(pre_s2)) >> F;
		pim_mag_c = (pim_s2[SW-1] ? SW'(-pim_s2) : SW'(pim_s2)) >> F;
		lre_mag_c = SW'(lin_re_s2[W] ? WL'(-lin_re_s2) : WL'(lin_re_s2));
		lim_mag_c = SW'(lin_im_s2[W] ? WL'(-lin_im_s2) : WL'(lin_im_s2));
		rre0_c    = XW'(nre_mag_c) << F;
		rim0_c    = XW'(nim_mag_c) << F;
		dtop_c    = XW'(den_s2) << QB;
		case (kind_s2)
			KIND_ADD, KIND_SUB, KIND_CONJ: begin
				sa_c = sat_sm(lin_re_s2[W], lre_mag_c);
				sb_c = sat_sm(lin_im_s2[W], lim_mag_c);
			end
			KIND_MUL, KIND_SCL: begin
				sa_c = sat_sm(pre_s2[SW-1], pre_mag_c);
				sb_c = sat_sm(pim_s2[SW-1], pim_mag_c);
			end
			default: begin
				sa_c = '0;
				sb_c = '0;
			end
		endcase
		dre_c = sa_c[W-1:0];
		dim_c = sb_c[W-1:0];
		dov_c = sa_c[W] | sb_c[W];
	end

	logic          rre_nx [NI];
	logic [XW-1:0] rre_v  [NI];
	logic [XW-1:0] rim_v  [NI];
	logic [QB-1:0] qre_v  [NI];
	logic [QB-1:0] qim_v  [NI];
	logic [PW-1:0] x_v    [NI];
	logic [RW-1:0] srem_v [NI];
	logic [W-1:0]  root_v [NI];

	always_comb begin
		logic [XW-1:0] dsh;
		logic [RW-1:0] trem;
		logic [RW-1:0] tt;
		for (int i = 0; i < NI; i++) begin
			dsh = XW'(den_sd[i]) << (QB - 1 - i);
			if (rem_re_sd[i] >= dsh) begin
				rre_v[i] = rem_re_sd[i] - dsh;
				qre_v[i] = {q_re_sd[i][QB-2:0], 1'b1};
			end else begin
				rre_v[i] = rem_re_sd[i];
				qre_v[i] = {q_re_sd[i][QB-2:0], 1'b0};
			end
			if (rem_im_sd[i] >= dsh) begin
				rim_v[i] = rem_im_sd[i] - dsh;
				qim_v[i] = {q_im_sd[i][QB-2:0], 1'b1};
			end else begin
				rim_v[i] = rem_im_sd[i];
				qim_v[i] = {q_im_sd[i][QB-2:0], 1'b0};
			end
			rre_nx[i] = 1'b0;
			trem = {srem_sd[i][RW-3:0], x_sd[i][PW-1 -: 2]};
			tt   = RW'({root_sd[i], 2'b01});
			if (i < W) begin
				x_v[i] = x_sd[i] << 2;
				if (trem >= tt) begin
					srem_v[i] = trem - tt;
					root_v[i] = {root_sd[i][W-2:0], 1'b1};
				end else begin
					srem_v[i] = trem;
					root_v[i] = {root_sd[i][W-2:0], 1'b0};
				end
			end else begin
				x_v[i]    = x_sd[i];
				srem_v[i] = srem_sd[i];
				root_v[i] = root_sd[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NI; i++) vld_sd[i] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s2;
			for (int i = 0; i < NI; i++) vld_sd[i+1] <= vld_sd[i] | rre_nx[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_sd[0]   <= kind_s2;
			dre_sd[0]    <= dre_c;
			dim_sd[0]    <= dim_c;
			dov_sd[0]    <= dov_c;
			dz_sd[0]     <= (kind_s2 == KIND_DIV) && (den_s2 == '0);
			den_sd[0]    <= den_s2;
			neg_re_sd[0] <= nre_neg_c;
			neg_im_sd[0] <= nim_neg_c;
			big_re_sd[0] <= rre0_c >= dtop_c;
			big_im_sd[0] <= rim0_c >= dtop_c;
			rem_re_sd[0] <= rre0_c;
			rem_im_sd[0] <= rim0_c;
			q_re_sd[0]   <= '0;
			q_im_sd[0]   <= '0;
			x_sd[0]      <= nrm_s2;
			srem_sd[0]   <= '0;
			root_sd[0]   <= '0;
			for (int i = 0; i < NI; i++) begin
				kind_sd[i+1]   <= kind_sd[i];
				dre_sd[i+1]    <= dre_sd[i];
				dim_sd[i+1]    <= dim_sd[i];
				dov_sd[i+1]    <= dov_sd[i];
				dz_sd[i+1]     <= dz_sd[i];
				den_sd[i+1]    <= den_sd[i];
				neg_re_sd[i+1] <= neg_re_sd[i];
				neg_im_sd[i+1] <= neg_im_sd[i];
				big_re_sd[i+1] <= big_re_sd[i];
				big_im_sd[i+1] <= big_im_sd[i];
				rem_re_sd[i+1] <= rre_v[i];
				rem_im_sd[i+1] <= rim_v[i];
				q_re_sd[i+1]   <= qre_v[i];
				q_im_sd[i+1]   <= qim_v[i];
				x_sd[i+1]      <= x_v[i];
				srem_sd[i+1]   <= srem_v[i];
				root_sd[i+1]   <= root_v[i];
			end
		end
	end

	// final select into the output register
	logic [W-1:0] fre_c, fim_c;
	logic         fov_c, fdz_c;
	logic [W:0]   qa_c, qb_c, rt_c;

	always_comb begin
		qa_c  = big_re_sd[NI] ? {1'b1, ~neg_re_sd[NI], {(W-1){1'b1}}} ^
			{1'b0, 1'b0, {(W-1){neg_re_sd[NI]}}}
			: sat_sm(neg_re_sd[NI], SW'(q_re_sd[NI]));
		qb_c  = big_im_sd[NI] ? {1'b1, ~neg_im_sd[NI], {(W-1){1'b1}}} ^
			{1'b0, 1'b0, {(W-1){neg_im_sd[NI]}}}
			: sat_sm(neg_im_sd[NI], SW'(q_im_sd[NI]));
		qa_c[W-1] = big_re_sd[NI] ? neg_re_sd[NI] : qa_c[W-1];
		qb_c[W-1] = big_im_sd[NI] ? neg_im_sd[NI] : qb_c[W-1];
		rt_c  = sat_sm(1'b0, SW'(root_sd[NI]));
		fdz_c = 1'b0;
		case (kind_sd[NI])
			KIND_DIV: begin
				if (dz_sd[NI]) begin
					fre_c = '0;
					fim_c = '0;
					fov_c = 1'b0;
					fdz_c = 1'b1;
				end else begin
					fre_c = qa_c[W-1:0];
					fim_c = qb_c[W-1:0];
					fov_c = qa_c[W] | qb_c[W];
				end
			end
			KIND_MAG: begin
				fre_c = rt_c[W-1:0];
				fim_c = '0;
				fov_c = rt_c[W];
			end
			default: begin
				fre_c = dre_sd[NI];
				fim_c = dim_sd[NI];
				fov_c = dov_sd[NI];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_sd[NI];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_re         <= fre_c;
			res_im         <= fim_c;
			overflow       <= fov_c;
			divide_by_zero <= fdz_c;
		end
	end

endmodule

/* src/cau_checker.sv */
// ----------------------------------------------------------------------------
// cau_assert
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_assert #(
	parameter int DATA_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [DATA_WIDTH-1:0] res_re,
	input logic signed [DATA_WIDTH-1:0] res_im,
	input logic                         overflow,
	input logic                         divide_by_zero
);

	a_stall_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow a blocked output beat");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide by zero beat carries a nonzero result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(res_im)
			&& $stable(overflow) && $stable(divide_by_zero))
		else $error("stalled output beat changed");

endmodule

bind complex_arithmetic_unit_top cau_assert #(
	.DATA_WIDTH(DATA_WIDTH)
) u_cau_assert (.*);
